[sv/stc_pkg.sv]
// Shared types and constants for the sloppy threshold counter.
// Used by every module of the block; depends on nothing else.
package stc_pkg;

    localparam int DEFAULT_NUM_SOURCES = 64;

    localparam int THR_W   = 16;
    localparam int ACT_W   = 7;
    localparam int SRC_W   = 6;
    localparam int TOTAL_W = 48;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1024;
    localparam logic [ACT_W-1:0] ACTIVE_RESET    = 7'd64;

    localparam logic KIND_INC  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLUSH_THRESHOLD = 1'b0,
        REG_ACTIVE_SOURCES  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INC,
        S_SUM,
        S_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               flushed;
    } result_t;

endpackage

[sv/sloppy_threshold_counter_unit.sv]
// Top level of the sloppy threshold counter: configuration registers and wiring.
// Depends on stc_pkg, stc_mem, stc_seq and stc_out.
//
// Approximate counter with one 16-bit local count per source, kept in a synchronous
// memory, and a 48-bit global count. An increment transaction reads the source's local
// count when it is accepted, then in S_INC writes it back and folds it into the global
// count when it reaches flush_threshold. A read-total transaction walks the memory one
// entry per cycle in S_SUM, or goes straight to S_EMIT when no source is active. After
// reset the block clears the local-count memory one entry per cycle and accepts no
// transaction until every entry of it is cleared; configuration writes
// are taken at any time. Results go through an output register, so a new input
// transaction is accepted while the previous result still waits to be taken; when a
// finished result finds that register still full, the block holds it and accepts
// nothing until the consumer takes the older one.
module sloppy_threshold_counter_unit
    import stc_pkg::*;
#(
    parameter int NUM_SOURCES = DEFAULT_NUM_SOURCES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [SRC_W-1:0]      source,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TOTAL_W-1:0]    total,
    output logic                  flushed
);

    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    logic [THR_W-1:0] threshold_reg, threshold_next;
    logic [ACT_W-1:0] active_reg, active_next;

    logic             out_free;
    logic             res_load;
    result_t          res;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [THR_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [THR_W-1:0] mem_rdata;

    always_comb
    begin
        threshold_next = threshold_reg;
        active_next    = active_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FLUSH_THRESHOLD: threshold_next = cfg_data[THR_W-1:0];
                REG_ACTIVE_SOURCES:  active_next    = cfg_data[ACT_W-1:0];
                default:             threshold_next = threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            active_reg    <= ACTIVE_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
            active_reg    <= active_next;
        end
    end

    stc_mem #(
        .DEPTH (NUM_SOURCES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    stc_seq #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .source          (source),
        .flush_threshold (threshold_reg),
        .active_sources  (active_reg),
        .out_free        (out_free),
        .res_load        (res_load),
        .res             (res),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    stc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .total     (total),
        .flushed   (flushed)
    );

endmodule

[sv/stc_mem.sv]
// Local-count store: one write port, one read port, registered read data.
// Depends on stc_pkg for the data width.
module stc_mem
    import stc_pkg::*;
#(
    parameter int DEPTH = DEFAULT_NUM_SOURCES,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [THR_W-1:0] wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [THR_W-1:0] rdata
);

    logic [THR_W-1:0] mem [DEPTH];
    logic [THR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/stc_seq.sv]
// Sequencer and datapath: clearing pass, increment read-modify-write and read-total walk.
// Depends on stc_pkg; drives the stc_mem ports and the stc_out load interface.
module stc_seq
    import stc_pkg::*;
#(
    parameter int NUM_SOURCES = DEFAULT_NUM_SOURCES,
    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1,
    localparam int CNT_W = ($clog2(NUM_SOURCES + 1) > ACT_W) ? $clog2(NUM_SOURCES + 1) : ACT_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kind,
    input  logic [SRC_W-1:0] source,
    input  logic [THR_W-1:0] flush_threshold,
    input  logic [ACT_W-1:0] active_sources,
    input  logic             out_free,
    output logic             res_load,
    output result_t          res,
    output logic             mem_we,
    output logic [IDX_W-1:0] mem_waddr,
    output logic [THR_W-1:0] mem_wdata,
    output logic [IDX_W-1:0] mem_raddr,
    input  logic [THR_W-1:0] mem_rdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);

    seq_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   clr_ptr_reg, clr_ptr_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic               drop_reg, drop_next;
    logic [TOTAL_W-1:0] acc_reg, acc_next;
    logic [TOTAL_W-1:0] global_reg, global_next;
    result_t            res_reg, res_next;

    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   src_ext;
    logic               src_ok;
    logic               accept;
    logic [THR_W:0]     cnt_inc;
    logic               flush;
    logic [TOTAL_W-1:0] glob_add;
    logic [TOTAL_W-1:0] acc_sum;
    logic               sum_done;

    // An active count beyond the store acts as the store depth.
    assign n_eff = (CNT_W'(active_sources) > CNT_W'(NUM_SOURCES)) ?
                   CNT_W'(NUM_SOURCES) : CNT_W'(active_sources);
    assign src_ext  = CNT_W'(source);
    assign src_ok   = src_ext < n_eff;
    assign accept   = in_valid && in_ready;
    assign cnt_inc  = {1'b0, mem_rdata} + (THR_W + 1)'(1);
    assign flush    = !drop_reg && (cnt_inc >= {1'b0, flush_threshold});
    assign glob_add = global_reg + TOTAL_W'(cnt_inc);
    assign acc_sum  = acc_reg + TOTAL_W'(mem_rdata);
    assign sum_done = ptr_reg == n_eff;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_ptr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_INC)
                    begin
                        state_next = S_INC;
                    end
                    else if (n_eff == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_INC:
            begin
                state_next = out_free ? S_IDLE : S_EMIT;
            end
            S_SUM:
            begin
                if (sum_done)
                begin
                    state_next = out_free ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_ptr_reg;
        mem_wdata = '0;
        mem_raddr = addr_reg;
        res_load  = 1'b0;
        res       = res_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = (kind == KIND_INC) ? src_ext[IDX_W-1:0] : '0;
            end
            S_INC:
            begin
                mem_we      = !drop_reg;
                mem_waddr   = addr_reg;
                mem_wdata   = flush ? '0 : cnt_inc[THR_W-1:0];
                res.total   = flush ? glob_add : global_reg;
                res.flushed = flush;
                res_load    = out_free;
            end
            S_SUM:
            begin
                mem_raddr = ptr_reg[IDX_W-1:0];
                if (sum_done)
                begin
                    res.total   = acc_sum;
                    res.flushed = 1'b0;
                    res_load    = out_free;
                end
            end
            S_EMIT:
            begin
                res_load = out_free;
            end
            default:
            begin
                res = res_reg;
            end
        endcase
    end

    always_comb
    begin
        clr_ptr_next = clr_ptr_reg;
        ptr_next     = ptr_reg;
        addr_next    = addr_reg;
        drop_next    = drop_reg;
        acc_next     = acc_reg;
        global_next  = global_reg;
        res_next     = res_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_ptr_next = clr_ptr_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next = src_ext[IDX_W-1:0];
                    drop_next = !src_ok;
                    acc_next  = global_reg;
                    ptr_next  = CNT_W'(1);
                    res_next.total   = global_reg;
                    res_next.flushed = 1'b0;
                end
            end
            S_INC:
            begin
                if (flush)
                begin
                    global_next = glob_add;
                end
                res_next = res;
            end
            S_SUM:
            begin
                acc_next = acc_sum;
                ptr_next = ptr_reg + CNT_W'(1);
                res_next = res;
            end
            S_EMIT:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_ptr_reg <= '0;
            global_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            global_reg  <= global_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        addr_reg <= addr_next;
        drop_reg <= drop_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_inc_goes_to_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_INC) |=> state_reg == S_INC)
        else $error("accepted increment did not enter the read-modify-write step");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_INC))
        else $error("local store written outside clearing or increment");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded into a full output register");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |-> (ptr_reg <= n_eff && ptr_reg != '0))
        else $error("read walk pointer out of range");

    a_flush_only_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.flushed) |-> state_reg == S_INC || state_reg == S_EMIT)
        else $error("flush reported outside an increment");
`endif

endmodule

[sv/stc_out.sv]
// Output register: holds one result transaction until the consumer takes it.
// Depends on stc_pkg for the result type.
module stc_out
    import stc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  result_t            res,
    output logic               free,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TOTAL_W-1:0] total,
    output logic               flushed
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign total     = data_reg.total;
    assign flushed   = data_reg.flushed;

endmodule

[verif/sloppy_threshold_counter_unit_tb.sv]
// Self-checking testbench for sloppy_threshold_counter_unit: a queue-fed driver,
// a result monitor and a cycle-free predictor of the counter state.
// Depends on stc_pkg and the sloppy_threshold_counter_unit RTL.
`timescale 1ns / 1ps

module sloppy_threshold_counter_unit_tb;
    import stc_pkg::*;

    localparam int NUM_SOURCES = DEFAULT_NUM_SOURCES;

    typedef struct packed {
        logic             kind;
        logic [SRC_W-1:0] source;
    } count_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = KIND_INC;
    logic [SRC_W-1:0]      source = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [TOTAL_W-1:0]    total;
    logic                  flushed;

    // Predictor state, mirrored from the configuration writes and accepted requests.
    logic [THR_W-1:0]   cfg_threshold;
    logic [ACT_W-1:0]   cfg_active;
    logic [15:0]        local_tally [NUM_SOURCES];
    logic [TOTAL_W-1:0] global_tally;

    count_req_t pending_reqs[$];
    result_t    expected_results[$];

    int unsigned error_count = 0;
    int unsigned inc_count = 0;
    int unsigned fold_count = 0;
    int unsigned drop_count = 0;
    int unsigned read_count = 0;
    int unsigned setting_count = 0;
    logic        no_idle = 1'b0;

    sloppy_threshold_counter_unit #(
        .NUM_SOURCES(NUM_SOURCES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .source(source),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .total(total),
        .flushed(flushed)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned live_sources();
        return (cfg_active > NUM_SOURCES) ? NUM_SOURCES : int'(cfg_active);
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // Updates the mirrored counter state for one request and returns its result.
    function automatic result_t apply_request(count_req_t req);
        result_t     res;
        int unsigned n_live;
        logic [16:0] bumped;
        n_live = live_sources();
        res.flushed = 1'b0;
        if (req.kind == KIND_READ) begin
            read_count++;
            res.total = global_tally;
            for (int i = 0; i < n_live; i++)
                res.total += local_tally[i];
        end
        else begin
            inc_count++;
            if (req.source < n_live) begin
                bumped = {1'b0, local_tally[req.source]} + 17'd1;
                if (bumped >= cfg_threshold) begin
                    global_tally += bumped;
                    local_tally[req.source] = '0;
                    res.flushed = 1'b1;
                    fold_count++;
                end
                else begin
                    local_tally[req.source] = bumped[15:0];
                end
            end
            else begin
                drop_count++;
            end
            res.total = global_tally;
        end
        return res;
    endfunction

    // Driver: presents queued requests and predicts each one as it is accepted.
    int unsigned send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin : driver
        count_req_t req;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_request('{kind: kind, source: source}));
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_reqs.size() > 0) begin
                    req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    kind <= req.kind;
                    source <= req.source;
                    send_gap <= draw_gap();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls at random and checks each result transaction in order.
    int unsigned recv_stall = 0;
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t     want;
        int unsigned stall_n;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_stall <= 0;
        end
        else begin
            stall_n = recv_stall;
            if (out_valid && out_ready) begin
                stall_n = draw_gap();
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result total %h flushed %b",
                             $time, total, flushed);
                end
                else begin
                    want = expected_results.pop_front();
                    if (total !== want.total) begin
                        error_count++;
                        $display("%0t: total mismatch, expected %h actual %h",
                                 $time, want.total, total);
                    end
                    if (flushed !== want.flushed) begin
                        error_count++;
                        $display("%0t: flushed mismatch, expected %b actual %b",
                                 $time, want.flushed, flushed);
                    end
                end
            end
            if (stall_n > 0) begin
                out_ready <= 1'b0;
                recv_stall <= stall_n - 1;
            end
            else begin
                out_ready <= 1'b1;
                recv_stall <= 0;
            end
        end
    end

    task automatic push_req(logic k, int unsigned src);
        pending_reqs.push_back('{kind: k, source: src[SRC_W-1:0]});
    endtask

    // Holds off until every queued request has been sent and answered.
    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FLUSH_THRESHOLD)
            cfg_threshold = value;
        else
            cfg_active = value[ACT_W-1:0];
        @(negedge clk);
    endtask

    // Mostly increments from live sources, a few reads and a few dropped increments.
    task automatic push_random(int unsigned quota);
        int unsigned useful;
        int unsigned n_live;
        int unsigned roll;
        int unsigned src;
        useful = 0;
        n_live = live_sources();
        while (useful < quota) begin
            roll = $urandom_range(0, 99);
            if (roll < 8 || (n_live == 0 && roll < 40)) begin
                push_req(KIND_READ, $urandom_range(0, 63));
                useful++;
            end
            else begin
                if (roll < 88 && n_live > 0)
                    src = $urandom_range(0, n_live - 1);
                else
                    src = $urandom_range(0, 63);
                push_req(KIND_INC, src);
                if (src < n_live)
                    useful++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [THR_W-1:0] thr;
        logic [ACT_W-1:0] act;
        cfg_threshold = THRESHOLD_RESET;
        cfg_active = ACTIVE_RESET;
        global_tally = '0;
        foreach (local_tally[i])
            local_tally[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset settings, then each register at its extremes.
        setting_count++;
        push_req(KIND_READ, 0);
        push_req(KIND_INC, 0);
        push_req(KIND_INC, 63);
        push_req(KIND_READ, 63);
        drain();
        write_reg(REG_FLUSH_THRESHOLD, 16'd1);
        setting_count++;
        push_req(KIND_INC, 0);
        push_req(KIND_INC, 63);
        push_req(KIND_READ, 0);
        drain();
        // A zero threshold folds on every increment.
        write_reg(REG_FLUSH_THRESHOLD, 16'd0);
        setting_count++;
        push_req(KIND_INC, 5);
        drain();
        // With no active source every increment is dropped.
        write_reg(REG_ACTIVE_SOURCES, 16'd0);
        setting_count++;
        push_req(KIND_INC, 0);
        push_req(KIND_READ, 42);
        drain();
        // An active count beyond the store behaves as the full store.
        write_reg(REG_ACTIVE_SOURCES, 16'd127);
        write_reg(REG_FLUSH_THRESHOLD, 16'd3);
        setting_count++;
        push_req(KIND_INC, 63);
        push_req(KIND_INC, 63);
        push_req(KIND_READ, 0);
        drain();
        write_reg(REG_ACTIVE_SOURCES, 16'd1);
        write_reg(REG_FLUSH_THRESHOLD, 16'd65535);
        setting_count++;
        push_req(KIND_INC, 1);
        push_req(KIND_INC, 0);
        push_req(KIND_INC, 0);
        push_req(KIND_READ, 0);
        drain();
        write_reg(REG_ACTIVE_SOURCES, 16'd64);
        setting_count++;
        push_req(KIND_READ, 0);
        drain();

        // Random phases, each under its own settings; every phase ends drained.
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: begin thr = 16'd1;     act = 7'd64;  end
                1: begin thr = 16'd65535; act = 7'd64;  end
                2: begin thr = 16'd0;     act = 7'd127; end
                3: begin thr = 16'd4;     act = 7'd0;   end
                4: begin thr = 16'd2;     act = 7'd1;   end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        thr = THR_W'($urandom_range(100, 65535));
                    else
                        thr = THR_W'($urandom_range(1, 12));
                    act = ACT_W'($urandom_range(0, 1) ? $urandom_range(2, 64)
                                                      : $urandom_range(65, 127));
                end
            endcase
            write_reg(REG_FLUSH_THRESHOLD, thr);
            write_reg(REG_ACTIVE_SOURCES, {9'd0, act});
            setting_count++;
            no_idle = (phase % 3 == 2);
            push_random((act == 0) ? 30 : 165);
            drain();
        end
        no_idle = 1'b0;

        repeat (80) @(posedge clk);
        $display("summary: %0d increments (%0d folded, %0d dropped) and %0d reads",
                 inc_count, fold_count, drop_count, read_count);
        $display("summary: %0d register settings, %0d mismatches",
                 setting_count, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
sv/stc_pkg.sv
sv/stc_mem.sv
sv/stc_seq.sv
sv/stc_out.sv
sv/sloppy_threshold_counter_unit.sv
verif/sloppy_threshold_counter_unit_tb.sv
